>>> sv/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared widths, status codes and the dictionary entry type.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // Field widths of the code stream, the results and the dictionary.
   localparam int CODE_W  = 16;
   localparam int IDX_W   = 9;
   localparam int NF_W    = 10;
   localparam int DATA_W  = 64;
   localparam int CNT_W   = 4;
   localparam int ST_W    = 2;
   localparam int BYTE_W  = 8;

   // Reserved code that restarts the dictionary.
   localparam logic [CODE_W-1:0] RESET_CODE = 16'hFFFE;
   // First code that lives in the dictionary memory.
   localparam logic [NF_W-1:0] FIRST_DYN_CODE = 10'd256;
   // Reset value of the code limit register.
   localparam logic [NF_W-1:0] LIMIT_RESET = 10'd512;

   // Result status codes.
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_RESET   = 2'd1;
   localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

   // One dictionary entry.
   typedef struct packed {
      logic [IDX_W-1:0]  prefix;
      logic [BYTE_W-1:0] suffix;
      logic [BYTE_W-1:0] first;
      logic [IDX_W-1:0]  length;
   } dict_entry_type;

endpackage

>>> sv/lzwd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder code channel
// Valid/ready channel that carries one 16-bit code per transfer.
// ----------------------------------------------------------------------------
interface lzwd_req_if;
   logic                        valid;
   logic                        ready;
   logic [lzwd_pkg::CODE_W-1:0] code;

   modport source (output valid, output code, input ready);
   modport sink (input valid, input code, output ready);
endinterface

>>> sv/lzwd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder result channel
// Valid/ready channel that carries up to eight decoded bytes per transfer.
// ----------------------------------------------------------------------------
interface lzwd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lzwd_pkg::DATA_W-1:0] data;
   logic [lzwd_pkg::CNT_W-1:0]  byte_count;
   logic                        last;
   logic [lzwd_pkg::ST_W-1:0]   status;

   modport source (output valid, output data, output byte_count, output last,
                   output status, input ready);
   modport sink (input valid, input data, input byte_count, input last,
                 input status, output ready);
endinterface

>>> sv/lzwd_dict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW dictionary
// Entry memory with one write and one registered read port. Codes below 256
// are the fixed single-byte strings and are produced without the memory.
// ----------------------------------------------------------------------------
module lzwd_dict #(
   parameter int DICT_ENTRIES = 512
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [lzwd_pkg::IDX_W-1:0]     wr_addr,
   input  lzwd_pkg::dict_entry_type       wr_entry,
   input  logic [lzwd_pkg::IDX_W-1:0]     rd_addr,
   output lzwd_pkg::dict_entry_type       rd_entry
);

   lzwd_pkg::dict_entry_type mem [DICT_ENTRIES];
   lzwd_pkg::dict_entry_type q_ff;
   logic [lzwd_pkg::IDX_W-1:0] addr_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      q_ff    <= mem[rd_addr];
      addr_ff <= rd_addr;
   end

   // The root codes hold their own byte with length one.
   always_comb begin
      if (addr_ff[lzwd_pkg::IDX_W-1] == 1'b0) begin
         rd_entry.prefix = '0;
         rd_entry.suffix = addr_ff[lzwd_pkg::BYTE_W-1:0];
         rd_entry.first  = addr_ff[lzwd_pkg::BYTE_W-1:0];
         rd_entry.length = lzwd_pkg::IDX_W'(1);
      end else begin
         rd_entry = q_ff;
      end
   end

endmodule

>>> sv/lzwd_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW byte stack
// Scratch memory that holds one unwound string, with a registered read.
// ----------------------------------------------------------------------------
module lzwd_stack #(
   parameter int DICT_ENTRIES = 512
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [lzwd_pkg::IDX_W-1:0]      wr_addr,
   input  logic [lzwd_pkg::BYTE_W-1:0]     wr_data,
   input  logic [lzwd_pkg::IDX_W-1:0]      rd_addr,
   output logic [lzwd_pkg::BYTE_W-1:0]     rd_data
);

   logic [lzwd_pkg::BYTE_W-1:0] mem [DICT_ENTRIES];
   logic [lzwd_pkg::BYTE_W-1:0] q_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff <= mem[rd_addr];
   end

   assign rd_data = q_ff;

endmodule

>>> sv/lzw_code_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW code stream decoder
// Decodes one 16-bit LZW code per input transfer into result transfers of
// up to eight bytes each.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan takes one code per transfer. req_chan.ready is high only while
//    the sequencer is idle; one code is worked on at a time.
//  - rsp_chan gives one or more results per code, first byte in bits 7:0,
//    with last set on the final result of the code. Reset codes and invalid
//    codes give a single empty result with status 1 or 2.
//  - csr_wr_en/csr_wr_data write the code limit; write it only while idle.
// Timing: a code that adds an entry first passes through S_RDP, S_RDC and
//  S_ADD. The dictionary read port follows the prefix chain one entry per
//  cycle, and the byte stack read port gives one byte a cycle while a chunk
//  is packed; the flow halts while a result waits for the output register.
//  Reset and invalid codes go from idle straight to the output state.
// Reset: the dictionary falls back to the 256 root strings, the code limit
//  to 512, and the output register is emptied. No clearing pass is needed.
// Stall: a finished result waits in the output register; the decoder holds
//  its next result until that register frees up, and takes no new code
//  before the last result of the current one is loaded.
// ----------------------------------------------------------------------------
module lzw_code_stream_decoder_unit #(
   parameter int DICT_ENTRIES = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   lzwd_req_if.sink                     req_chan,
   lzwd_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [lzwd_pkg::NF_W-1:0]    csr_wr_data
);

   localparam int IW = lzwd_pkg::IDX_W;
   localparam int NW = lzwd_pkg::NF_W;
   localparam int BW = lzwd_pkg::BYTE_W;
   localparam logic [NW-1:0] DICT_LIMIT = NW'(DICT_ENTRIES);
   localparam logic [IW-1:0] FIRST_IDX = IW'(lzwd_pkg::FIRST_DYN_CODE);

   typedef enum logic [3:0] {
      S_IDLE, S_RDP, S_RDC, S_ADD, S_UNW0, S_LEN, S_WALK, S_FILL, S_OUT
   } state_type;

   // Sequencer registers.
   state_type                      state_ff, state_in;
   logic [NW-1:0]                  limit_ff, limit_in;
   logic [NW-1:0]                  nf_ff, nf_in;
   logic [IW-1:0]                  prev_ff, prev_in;
   logic                           have_ff, have_in;
   logic [lzwd_pkg::CODE_W-1:0]    code_ff, code_in;
   logic [BW-1:0]                  pfirst_ff, pfirst_in;
   logic [IW-1:0]                  plen_ff, plen_in;
   logic [IW-1:0]                  cur_ff, cur_in;
   logic [NW-1:0]                  len_ff, len_in;
   logic [NW-1:0]                  pos_ff, pos_in;
   logic [NW-1:0]                  rdi_ff, rdi_in;
   logic [NW-1:0]                  base_ff, base_in;
   logic [NW-1:0]                  recv_ff, recv_in;
   logic [2:0]                     n_ff, n_in;
   logic                           pend_ff, pend_in;
   logic [lzwd_pkg::DATA_W-1:0]    acc_ff, acc_in;
   logic [lzwd_pkg::DATA_W-1:0]    cdata_ff, cdata_in;
   logic [lzwd_pkg::CNT_W-1:0]     ccnt_ff, ccnt_in;
   logic                           clast_ff, clast_in;
   logic [lzwd_pkg::ST_W-1:0]      cst_ff, cst_in;
   logic                           rv_ff, rv_in;
   logic [lzwd_pkg::DATA_W-1:0]    rdata_ff, rdata_in;
   logic [lzwd_pkg::CNT_W-1:0]     rcnt_ff, rcnt_in;
   logic                           rlast_ff, rlast_in;
   logic [lzwd_pkg::ST_W-1:0]      rst_ff, rst_in;

   // Memory ports.
   logic                           dict_we;
   lzwd_pkg::dict_entry_type       dict_wentry;
   logic [IW-1:0]                  dict_raddr;
   lzwd_pkg::dict_entry_type       ent;
   logic                           stk_we;
   logic [IW-1:0]                  stk_waddr;
   logic [BW-1:0]                  stk_wdata;
   logic [BW-1:0]                  stk_q;

   // Decode helpers.
   logic                           accept;
   logic [NW-1:0]                  limit_eff;
   logic                           room;
   logic [lzwd_pkg::CODE_W-1:0]    nf_wide;
   logic                           code_ok;
   logic                           code_below;
   logic [NW-1:0]                  ent_len;
   logic                           walk_step;
   logic                           issue;
   logic                           chunk_done;
   logic [lzwd_pkg::DATA_W-1:0]    acc_next;
   logic                           out_free;

   lzwd_dict #(.DICT_ENTRIES(DICT_ENTRIES)) u_dict (
      .clock    (clock),
      .wr_en    (dict_we),
      .wr_addr  (nf_ff[IW-1:0]),
      .wr_entry (dict_wentry),
      .rd_addr  (dict_raddr),
      .rd_entry (ent)
   );

   lzwd_stack #(.DICT_ENTRIES(DICT_ENTRIES)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (rdi_ff[IW-1:0]),
      .rd_data (stk_q)
   );

   // Handshake and code checks against the live dictionary size.
   assign accept     = req_chan.valid && req_chan.ready;
   assign limit_eff  = (limit_ff < DICT_LIMIT) ? limit_ff : DICT_LIMIT;
   assign room       = nf_ff < limit_eff;
   assign nf_wide    = lzwd_pkg::CODE_W'(nf_ff);
   assign code_ok    = (req_chan.code < nf_wide) || ((req_chan.code == nf_wide) && room);
   assign code_below = lzwd_pkg::CODE_W'(code_ff) < nf_wide;
   assign out_free   = !rv_ff || rsp_chan.ready;

   // Length of the string being unwound, with a zero or oversized length
   // read as one byte.
   assign ent_len = ((ent.length == '0) || (NW'(ent.length) > DICT_LIMIT)) ?
                    NW'(1) : NW'(ent.length);

   // Walk one link of the prefix chain while bytes remain above the root.
   assign walk_step = (state_ff == S_WALK) && (cur_ff >= FIRST_IDX) && (pos_ff != '0);

   // Stack reads for the chunk being packed.
   assign issue      = (state_ff == S_FILL) && (rdi_ff < len_ff) && ((rdi_ff - base_ff) < NW'(8));
   assign chunk_done = (n_ff == 3'd7) || ((recv_ff + NW'(1)) == len_ff);

   always_comb begin
      acc_next = acc_ff;
      acc_next[{n_ff, 3'b000} +: BW] = stk_q;
   end

   // New dictionary entry: previous string plus the first byte of the current.
   always_comb begin
      dict_we            = (state_ff == S_ADD);
      dict_wentry.prefix = prev_ff;
      dict_wentry.suffix = code_below ? ent.first : pfirst_ff;
      dict_wentry.first  = pfirst_ff;
      dict_wentry.length = plen_ff + IW'(1);
   end

   // Dictionary read address chosen by the sequencer.
   always_comb begin
      case (state_ff)
         S_RDP:   dict_raddr = prev_ff;
         S_WALK:  dict_raddr = ent.prefix;
         default: dict_raddr = code_ff[IW-1:0];
      endcase
   end

   // Stack writes during the chain walk; the root byte lands at position 0.
   always_comb begin
      stk_we    = (state_ff == S_WALK);
      stk_waddr = walk_step ? pos_ff[IW-1:0] : '0;
      stk_wdata = walk_step ? ent.suffix : ent.first;
   end

   // Sequencer next state.
   always_comb begin
      state_in  = state_ff;
      limit_in  = csr_wr_en ? csr_wr_data : limit_ff;
      nf_in     = nf_ff;
      prev_in   = prev_ff;
      have_in   = have_ff;
      code_in   = code_ff;
      pfirst_in = pfirst_ff;
      plen_in   = plen_ff;
      cur_in    = cur_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      rdi_in    = rdi_ff;
      base_in   = base_ff;
      recv_in   = recv_ff;
      n_in      = n_ff;
      pend_in   = issue;
      acc_in    = acc_ff;
      cdata_in  = cdata_ff;
      ccnt_in   = ccnt_ff;
      clast_in  = clast_ff;
      cst_in    = cst_ff;
      rv_in     = rv_ff && !rsp_chan.ready;
      rdata_in  = rdata_ff;
      rcnt_in   = rcnt_ff;
      rlast_in  = rlast_ff;
      rst_in    = rst_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               code_in  = req_chan.code;
               cdata_in = '0;
               ccnt_in  = '0;
               clast_in = 1'b1;
               if (req_chan.code == lzwd_pkg::RESET_CODE) begin
                  nf_in    = lzwd_pkg::FIRST_DYN_CODE;
                  prev_in  = '0;
                  have_in  = 1'b0;
                  cst_in   = lzwd_pkg::ST_RESET;
                  state_in = S_OUT;
               end else if (!have_ff) begin
                  if (req_chan.code < lzwd_pkg::CODE_W'(lzwd_pkg::FIRST_DYN_CODE)) begin
                     state_in = S_UNW0;
                  end else begin
                     cst_in   = lzwd_pkg::ST_INVALID;
                     state_in = S_OUT;
                  end
               end else if (!code_ok) begin
                  cst_in   = lzwd_pkg::ST_INVALID;
                  state_in = S_OUT;
               end else if (room) begin
                  state_in = S_RDP;
               end else begin
                  state_in = S_UNW0;
               end
            end
         end
         S_RDP: begin
            state_in = S_RDC;
         end
         S_RDC: begin
            pfirst_in = ent.first;
            plen_in   = ent.length;
            state_in  = S_ADD;
         end
         S_ADD: begin
            nf_in    = nf_ff + NW'(1);
            state_in = S_UNW0;
         end
         S_UNW0: begin
            prev_in  = code_ff[IW-1:0];
            have_in  = 1'b1;
            cur_in   = code_ff[IW-1:0];
            state_in = S_LEN;
         end
         S_LEN: begin
            len_in   = ent_len;
            pos_in   = ent_len - NW'(1);
            state_in = S_WALK;
         end
         S_WALK: begin
            if (walk_step) begin
               cur_in = ent.prefix;
               pos_in = pos_ff - NW'(1);
            end else begin
               rdi_in   = '0;
               base_in  = '0;
               recv_in  = '0;
               n_in     = '0;
               acc_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (issue) begin
               rdi_in = rdi_ff + NW'(1);
            end
            if (pend_ff) begin
               recv_in = recv_ff + NW'(1);
               if (chunk_done) begin
                  cdata_in = acc_next;
                  ccnt_in  = lzwd_pkg::CNT_W'(n_ff) + lzwd_pkg::CNT_W'(1);
                  clast_in = (recv_ff + NW'(1)) == len_ff;
                  cst_in   = lzwd_pkg::ST_OK;
                  acc_in   = '0;
                  n_in     = '0;
                  base_in  = base_ff + NW'(8);
                  state_in = S_OUT;
               end else begin
                  acc_in = acc_next;
                  n_in   = n_ff + 3'd1;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rdata_in = cdata_ff;
               rcnt_in  = ccnt_ff;
               rlast_in = clast_ff;
               rst_in   = cst_ff;
               state_in = clast_ff ? S_IDLE : S_FILL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= lzwd_pkg::LIMIT_RESET;
         nf_ff    <= lzwd_pkg::FIRST_DYN_CODE;
         prev_ff  <= '0;
         have_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         nf_ff    <= nf_in;
         prev_ff  <= prev_in;
         have_ff  <= have_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
      code_ff   <= code_in;
      pfirst_ff <= pfirst_in;
      plen_ff   <= plen_in;
      cur_ff    <= cur_in;
      len_ff    <= len_in;
      pos_ff    <= pos_in;
      rdi_ff    <= rdi_in;
      base_ff   <= base_in;
      recv_ff   <= recv_in;
      n_ff      <= n_in;
      acc_ff    <= acc_in;
      cdata_ff  <= cdata_in;
      ccnt_ff   <= ccnt_in;
      clast_ff  <= clast_in;
      cst_ff    <= cst_in;
      rdata_ff  <= rdata_in;
      rcnt_ff   <= rcnt_in;
      rlast_ff  <= rlast_in;
      rst_ff    <= rst_in;
   end

   // Channel outputs.
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rv_ff;
   assign rsp_chan.data       = rdata_ff;
   assign rsp_chan.byte_count = rcnt_ff;
   assign rsp_chan.last       = rlast_ff;
   assign rsp_chan.status     = rst_ff;

   // The next free code never passes the dictionary size.
   assert property (@(posedge clock) disable iff (reset) nf_ff <= DICT_LIMIT)
      else $error("next free code beyond dictionary size");

   // Each walk step moves one position down the byte stack.
   assert property (@(posedge clock) disable iff (reset)
      walk_step |=> (pos_ff == $past(pos_ff) - NW'(1)))
      else $error("chain walk skipped a stack position");

   // A decoded result always carries at least one byte.
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && (rst_ff == lzwd_pkg::ST_OK)) |-> (rcnt_ff != '0))
      else $error("empty result with ok status");

   // A loaded result that is not taken stays in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_chan.ready) |=> (rv_ff && $stable(rdata_ff)))
      else $error("pending result lost under stall");

endmodule
